// ===== design/xsp_pkg.sv =====
// Shared types, codes and constants of the segment stream parser.
`timescale 1ns / 1ps

package xsp_pkg;

    // Default segment limit handed to the top level
    localparam int MAX_SEGMENTS_DEF = 64;

    // Record kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_ORDER     = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_TOO_MANY  = 3'd4;

    // Special words and addresses
    localparam logic [15:0] MARKER_WORD = 16'hFFFF;
    localparam logic [15:0] RUN_LO      = 16'h02E0;
    localparam logic [15:0] RUN_HI      = 16'h02E1;
    localparam logic [15:0] INIT_LO     = 16'h02E2;
    localparam logic [15:0] INIT_HI     = 16'h02E3;

    // Shortest valid file, in bytes
    localparam logic [2:0] MIN_FILE_BYTES = 3'd6;

    // One input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [15:0] end_address;
        logic [7:0]  data_byte;
        logic [5:0]  segment_index;
        logic [2:0]  status;
        logic [15:0] run_address;
        logic [15:0] init_address;
        logic [6:0]  segment_count;
        logic        last_of_run;
    } t_out_item;

    // Records produced by one accepted byte: an optional header or payload
    // record, then an optional status record
    typedef struct packed {
        logic      rec_vld;
        t_out_item rec;
        logic      sts_vld;
        t_out_item sts;
    } t_rec_pair;

endpackage

// ===== design/xsp_parser.sv =====
// Parser state and per-byte record generation.
`timescale 1ns / 1ps

module xsp_parser #(
    parameter int MAX_SEGMENTS = xsp_pkg::MAX_SEGMENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  xsp_pkg::t_in_item i_item,
    output xsp_pkg::t_rec_pair o_recs
);

    localparam int SegW = $clog2(MAX_SEGMENTS + 1);

    // Phase codes
    localparam logic [2:0] PH_START_LO = 3'd0;
    localparam logic [2:0] PH_START_HI = 3'd1;
    localparam logic [2:0] PH_END_LO   = 3'd2;
    localparam logic [2:0] PH_END_HI   = 3'd3;
    localparam logic [2:0] PH_PAYLOAD  = 3'd4;
    localparam logic [2:0] PH_DRAIN    = 3'd5;

    // Special segment targets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_RUN  = 2'd1;
    localparam logic [1:0] TGT_INIT = 2'd2;
    localparam logic [1:0] TGT_OVER = 2'd3;

    logic [2:0]      r_phase,      n_phase;
    logic [7:0]      r_low,        n_low;
    logic [15:0]     r_seg_start,  n_seg_start;
    logic [15:0]     r_next_addr,  n_next_addr;
    logic [16:0]     r_bytes_left, n_bytes_left;
    logic [1:0]      r_target,     n_target;
    logic [SegW-1:0] r_seg_total,  n_seg_total;
    logic [15:0]     r_run,        n_run;
    logic [15:0]     r_init,       n_init;
    logic [2:0]      r_tally,      n_tally;
    logic [2:0]      r_error,      n_error;

    logic [15:0] w_word;
    logic [16:0] w_left_dec;
    logic [SegW-1:0] w_prev_total;

    assign w_word       = {i_item.in_byte, r_low};
    assign w_left_dec   = (r_bytes_left != 17'd0) ? r_bytes_left - 17'd1 : r_bytes_left;
    assign w_prev_total = r_seg_total - 1'b1;

    // Next state and records for the byte at the input
    always_comb begin
        n_phase      = r_phase;
        n_low        = r_low;
        n_seg_start  = r_seg_start;
        n_next_addr  = r_next_addr;
        n_bytes_left = r_bytes_left;
        n_target     = r_target;
        n_seg_total  = r_seg_total;
        n_run        = r_run;
        n_init       = r_init;
        n_error      = r_error;
        n_tally      = (r_tally < xsp_pkg::MIN_FILE_BYTES) ? r_tally + 3'd1 : r_tally;
        o_recs       = '0;

        case (r_phase)
            PH_START_LO: begin
                n_low   = i_item.in_byte;
                n_phase = PH_START_HI;
            end
            PH_START_HI: begin
                // a marker word is skipped wherever a start word may stand
                if (w_word == xsp_pkg::MARKER_WORD) begin
                    n_phase = PH_START_LO;
                end else begin
                    n_seg_start = w_word;
                    n_phase     = PH_END_LO;
                end
            end
            PH_END_LO: begin
                n_low   = i_item.in_byte;
                n_phase = PH_END_HI;
            end
            PH_END_HI: begin
                if (w_word < r_seg_start) begin
                    n_error = xsp_pkg::ST_ORDER;
                    n_phase = PH_DRAIN;
                end else begin
                    n_bytes_left = {1'b0, w_word} - {1'b0, r_seg_start} + 17'd1;
                    n_next_addr  = r_seg_start;
                    if (r_seg_start == xsp_pkg::RUN_LO && w_word == xsp_pkg::RUN_HI) begin
                        n_target = TGT_RUN;
                    end else if (r_seg_start == xsp_pkg::INIT_LO &&
                                 w_word == xsp_pkg::INIT_HI) begin
                        n_target = TGT_INIT;
                    end else if (r_seg_total >= SegW'(MAX_SEGMENTS)) begin
                        n_target = TGT_OVER;
                    end else begin
                        n_target                   = TGT_NONE;
                        o_recs.rec_vld             = 1'b1;
                        o_recs.rec.kind            = xsp_pkg::KIND_HEADER;
                        o_recs.rec.address         = r_seg_start;
                        o_recs.rec.end_address     = w_word;
                        o_recs.rec.segment_index   = 6'(r_seg_total);
                        n_seg_total                = r_seg_total + 1'b1;
                    end
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (r_target == TGT_NONE) begin
                    o_recs.rec_vld           = 1'b1;
                    o_recs.rec.kind          = xsp_pkg::KIND_PAYLOAD;
                    o_recs.rec.address       = r_next_addr;
                    o_recs.rec.data_byte     = i_item.in_byte;
                    o_recs.rec.segment_index = 6'(w_prev_total);
                end else if (r_target == TGT_RUN || r_target == TGT_INIT) begin
                    // two-byte vector: hold low byte, latch on high byte
                    if (r_bytes_left == 17'd2) begin
                        n_low = i_item.in_byte;
                    end else if (r_target == TGT_RUN) begin
                        n_run = w_word;
                    end else begin
                        n_init = w_word;
                    end
                end
                n_next_addr  = r_next_addr + 16'd1;
                n_bytes_left = w_left_dec;
                if (w_left_dec == 17'd0) begin
                    if (r_target == TGT_OVER) begin
                        n_error = xsp_pkg::ST_TOO_MANY;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_phase = PH_START_LO;
                    end
                end
            end
            default: begin
                // drain: ignore bytes until the last one
            end
        endcase

        // status record on the last byte, then back to the reset state
        if (i_item.final_byte) begin
            o_recs.sts_vld = 1'b1;
            o_recs.sts.kind = xsp_pkg::KIND_STATUS;
            if (n_tally < xsp_pkg::MIN_FILE_BYTES) begin
                o_recs.sts.status = xsp_pkg::ST_SHORT;
            end else if (n_error != xsp_pkg::ST_OK) begin
                o_recs.sts.status = n_error;
            end else if (n_phase inside {PH_START_LO, PH_START_HI}) begin
                o_recs.sts.status = xsp_pkg::ST_OK;
            end else begin
                o_recs.sts.status = xsp_pkg::ST_TRUNCATED;
            end
            o_recs.sts.run_address   = n_run;
            o_recs.sts.init_address  = n_init;
            o_recs.sts.segment_count = 7'(n_seg_total);

            n_phase      = PH_START_LO;
            n_low        = '0;
            n_seg_start  = '0;
            n_next_addr  = '0;
            n_bytes_left = '0;
            n_target     = TGT_NONE;
            n_seg_total  = '0;
            n_run        = '0;
            n_init       = '0;
            n_tally      = '0;
            n_error      = xsp_pkg::ST_OK;
        end

        // flag the last record caused by this byte
        if (o_recs.sts_vld) begin
            o_recs.sts.last_of_run = 1'b1;
        end else if (o_recs.rec_vld) begin
            o_recs.rec.last_of_run = 1'b1;
        end
    end

    // State registers, updated per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START_LO;
            r_low        <= '0;
            r_seg_start  <= '0;
            r_next_addr  <= '0;
            r_bytes_left <= '0;
            r_target     <= TGT_NONE;
            r_seg_total  <= '0;
            r_run        <= '0;
            r_init       <= '0;
            r_tally      <= '0;
            r_error      <= xsp_pkg::ST_OK;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_low        <= n_low;
            r_seg_start  <= n_seg_start;
            r_next_addr  <= n_next_addr;
            r_bytes_left <= n_bytes_left;
            r_target     <= n_target;
            r_seg_total  <= n_seg_total;
            r_run        <= n_run;
            r_init       <= n_init;
            r_tally      <= n_tally;
            r_error      <= n_error;
        end
    end

    // A finished file leaves the parser in its reset state
    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.final_byte) |=>
            (r_phase == PH_START_LO && r_tally == 3'd0 && r_error == xsp_pkg::ST_OK))
        else $error("parser state not cleared after last byte");

    // Segment count never passes the limit
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_total <= SegW'(MAX_SEGMENTS))
        else $error("segment count over limit");

    // Inside a payload there is always at least one byte to go
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_bytes_left != 17'd0))
        else $error("payload phase with no bytes left");

endmodule

// ===== design/xsp_out_buf.sv =====
// Two-entry result queue between the parser and the output channel.
`timescale 1ns / 1ps

module xsp_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  xsp_pkg::t_rec_pair  i_recs,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output xsp_pkg::t_out_item  o_out_item,
    output logic                o_in_ready
);

    logic [1:0]         r_cnt, n_cnt;
    xsp_pkg::t_out_item r_q0, r_q1;
    logic               w_pop;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_q0;
    assign w_pop       = o_out_valid && i_out_ready;
    // room for a new byte once the queue is empty after this cycle's pop
    assign o_in_ready  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);

    // Occupancy
    always_comb begin
        if (i_push) begin
            n_cnt = {1'b0, i_recs.rec_vld} + {1'b0, i_recs.sts_vld};
        end else if (w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Queue entries: a push always lands in an empty queue
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q0 <= i_recs.rec_vld ? i_recs.rec : i_recs.sts;
            r_q1 <= i_recs.sts;
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue overflow");

    // With two entries only the second closes the transaction's results
    a_two_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!r_q0.last_of_run && r_q1.last_of_run))
        else $error("result order broken in queue");

    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_q0.last_of_run)
        else $error("single queued result not marked last");

    a_pair_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_recs.rec_vld && i_recs.sts_vld) |=> (r_cnt == 2'd2))
        else $error("record pair not queued");

endmodule

// ===== design/xex_segment_stream_parser_core.sv =====
// Top level of the segmented load file stream parser.
`timescale 1ns / 1ps

// Accepts one file byte per transaction and emits header, payload and final
// status records in file order. Throughput is one byte per clock while the
// output is ready; a final byte that also produces a header or payload record
// yields two records and holds the input while the two-entry result queue
// drains. Results appear in the cycle after their byte is accepted. Run and
// init vector segments produce no records; their values show up in the status
// record. A new file may start on the byte after a final byte.
module xex_segment_stream_parser_core #(
    parameter int MAX_SEGMENTS = xsp_pkg::MAX_SEGMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  xsp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output xsp_pkg::t_out_item o_out_item
);

    logic               w_accept;
    xsp_pkg::t_rec_pair w_recs;

    assign w_accept = i_in_valid && o_in_ready;

    // Parser state and record generation
    xsp_parser #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_recs   (w_recs)
    );

    // Result queue
    xsp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_recs      (w_recs),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_in_ready  (o_in_ready)
    );

endmodule
